/* hw/rtl/seven_segment_scan_formatter_macros.svh */
// ----------------------------------------------------------------------------
// seven segment scan formatter assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_SCAN_FORMATTER_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_FORMATTER_MACROS_SVH

// same-cycle implication
`define SSF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/ssf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_pkg
// types, codes and digit helpers for the seven segment scan formatter
// ----------------------------------------------------------------------------
package ssf_pkg;

   localparam int POS_W = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // display modes
   localparam logic [2:0] MODE_FREQ = 3'd1;
   localparam logic [2:0] MODE_DISTANCE = 3'd2;
   localparam logic [2:0] MODE_TIME = 3'd3;
   localparam logic [2:0] MODE_TEMP = 3'd4;
   localparam logic [2:0] MODE_ANALOG = 3'd5;

   // register select, address bit 2
   localparam logic REG_VIEW_MODE = 1'b0;
   localparam logic REG_ANALOG_SELECT = 1'b1;

   // character codes beyond the decimal digits
   localparam logic [3:0] CHAR_DASH = 4'd10;
   localparam logic [3:0] CHAR_BLANK = 4'd11;

   localparam logic [7:0] SEG_BLANK = 8'hFF;
   localparam logic [7:0] SEG_DP_MASK = 8'h7F;

   // reciprocals, exact for 16-bit dividends with a 32-bit shift
   localparam logic [31:0] RECIP_10 = 32'(64'h1_0000_0000 / 64'd10 + 64'd1);
   localparam logic [31:0] RECIP_100 = 32'(64'h1_0000_0000 / 64'd100 + 64'd1);
   localparam logic [31:0] RECIP_1000 = 32'(64'h1_0000_0000 / 64'd1000 + 64'd1);
   localparam logic [31:0] RECIP_10000 = 32'(64'h1_0000_0000 / 64'd10000 + 64'd1);

   typedef logic [4:0][3:0] bcd5_type;

   typedef struct packed {
      logic        action;
      logic [15:0] frequency;
      logic [9:0]  distance;
      logic [7:0]  time_hours;
      logic [7:0]  time_minutes;
      logic [7:0]  time_seconds;
      logic [15:0] temperature;
      logic [7:0]  light_level;
      logic [7:0]  pot_level;
   } item_type;

   typedef struct packed {
      bcd5_type   frequency;
      bcd5_type   distance;
      bcd5_type   temperature;
      bcd5_type   light;
      bcd5_type   pot;
      logic [7:0] hours;
      logic [7:0] minutes;
      logic [7:0] seconds;
   } reading_type;

   typedef struct packed {
      logic             fire;
      logic [POS_W-1:0] pos;
      logic             blink_on;
   } scan_type;

   typedef struct packed {
      logic [2:0] view_mode;
      logic       analog_select;
   } cfg_type;

   function automatic logic [15:0] div_recip(input logic [15:0] value,
                                             input logic [31:0] recip);
      logic [47:0] prod;
      prod = 48'(value) * 48'(recip);
      return prod[47:32];
   endfunction

   function automatic bcd5_type bcd_digits(input logic [15:0] value);
      logic [4:0][15:0] quot;
      bcd5_type         digits;
      quot[0] = value;
      quot[1] = div_recip(value, RECIP_10);
      quot[2] = div_recip(value, RECIP_100);
      quot[3] = div_recip(value, RECIP_1000);
      quot[4] = div_recip(value, RECIP_10000);
      for (int k = 0; k < 4; k++) begin
         digits[k] = 4'(quot[k] - ((quot[k+1] << 3) + (quot[k+1] << 1)));
      end
      digits[4] = quot[4][3:0];
      return digits;
   endfunction

   function automatic logic [7:0] seg_pattern(input logic [3:0] code);
      logic [7:0] seg;
      case (code)
         4'd0: seg = 8'hC0;
         4'd1: seg = 8'hF9;
         4'd2: seg = 8'hA4;
         4'd3: seg = 8'hB0;
         4'd4: seg = 8'h99;
         4'd5: seg = 8'h92;
         4'd6: seg = 8'h82;
         4'd7: seg = 8'hF8;
         4'd8: seg = 8'h80;
         4'd9: seg = 8'h90;
         CHAR_DASH: seg = 8'hBF;
         default: seg = SEG_BLANK;
      endcase
      return seg;
   endfunction

endpackage

/* hw/rtl/ssf_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_if
// valid/ready channels for reading words and digit words
// ----------------------------------------------------------------------------
interface ssf_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [15:0] frequency;
   logic [9:0]  distance;
   logic [7:0]  time_hours;
   logic [7:0]  time_minutes;
   logic [7:0]  time_seconds;
   logic [15:0] temperature;
   logic [7:0]  light_level;
   logic [7:0]  pot_level;

   modport source (
      output valid, action, frequency, distance, time_hours, time_minutes,
             time_seconds, temperature, light_level, pot_level,
      input  ready
   );
   modport sink (
      input  valid, action, frequency, distance, time_hours, time_minutes,
             time_seconds, temperature, light_level, pot_level,
      output ready
   );
endinterface

interface ssf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] digit_strobe;
   logic [7:0] segments;

   modport source (output valid, digit_strobe, segments, input ready);
   modport sink (input valid, digit_strobe, segments, output ready);
endinterface

/* hw/rtl/ssf_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_csr
// apb register file: display mode and analog source select
// ----------------------------------------------------------------------------
module ssf_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ssf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ssf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ssf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready,
   output ssf_pkg::cfg_type                   cfg
);

   logic [2:0] mode_ff, mode_in;
   logic       select_ff, select_in;
   logic       wr_en;

   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      mode_in = mode_ff;
      select_in = select_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            ssf_pkg::REG_VIEW_MODE: mode_in = csr_pwdata[2:0];
            ssf_pkg::REG_ANALOG_SELECT: select_in = csr_pwdata[0];
            default: mode_in = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ssf_pkg::MODE_FREQ;
         select_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         select_ff <= select_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         ssf_pkg::REG_VIEW_MODE: csr_prdata = ssf_pkg::CSR_DATA_W'(mode_ff);
         ssf_pkg::REG_ANALOG_SELECT: csr_prdata = ssf_pkg::CSR_DATA_W'(select_ff);
         default: csr_prdata = '0;
      endcase
   end

   assign cfg.view_mode = mode_ff;
   assign cfg.analog_select = select_ff;

endmodule

/* hw/rtl/ssf_scan_ctrl.sv */
`timescale 1ns / 1ps
`include "seven_segment_scan_formatter_macros.svh"
// ----------------------------------------------------------------------------
// ssf_scan_ctrl
// tick prescaler, digit position and blink phase counter
// ----------------------------------------------------------------------------
module ssf_scan_ctrl #(
   parameter int SCAN_DIVIDER = 10,
   parameter int BLINK_HALF_SCANS = 250
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              tick,
   output ssf_pkg::scan_type scan
);

   localparam int PRE_W = (SCAN_DIVIDER > 1) ? $clog2(SCAN_DIVIDER) : 1;
   localparam int BLINK_W = $clog2(2 * BLINK_HALF_SCANS);

   logic [PRE_W-1:0]         pre_ff, pre_in;
   logic [PRE_W:0]           pre_inc;
   logic [BLINK_W-1:0]       blink_ff, blink_in;
   logic [BLINK_W:0]         blink_inc;
   logic [ssf_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                     fire;

   always_comb begin
      pre_inc = {1'b0, pre_ff} + (PRE_W+1)'(1);
      blink_inc = {1'b0, blink_ff} + (BLINK_W+1)'(1);
      fire = tick && (pre_inc >= (PRE_W+1)'(SCAN_DIVIDER));
      pre_in = pre_ff;
      blink_in = blink_ff;
      pos_in = pos_ff;
      if (tick) begin
         pre_in = fire ? '0 : pre_inc[PRE_W-1:0];
      end
      if (fire) begin
         blink_in = (blink_inc >= (BLINK_W+1)'(2 * BLINK_HALF_SCANS)) ?
                    '0 : blink_inc[BLINK_W-1:0];
         pos_in = pos_ff + ssf_pkg::POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff <= '0;
         blink_ff <= '0;
         pos_ff <= '0;
      end else begin
         pre_ff <= pre_in;
         blink_ff <= blink_in;
         pos_ff <= pos_in;
      end
   end

   assign scan.fire = fire;
   assign scan.pos = pos_ff;
   assign scan.blink_on = (blink_inc <= (BLINK_W+1)'(BLINK_HALF_SCANS));

   `SSF_ASSERT_IMPLY(a_pre_range, clock, reset, 1'b1,
      (PRE_W+1)'(pre_ff) < (PRE_W+1)'(SCAN_DIVIDER), "prescaler out of range")
   `SSF_ASSERT_IMPLY(a_blink_range, clock, reset, 1'b1,
      (BLINK_W+1)'(blink_ff) < (BLINK_W+1)'(2 * BLINK_HALF_SCANS), "blink count out of range")
   `SSF_ASSERT_NEXT(a_pos_step, clock, reset, fire,
      pos_ff == ssf_pkg::POS_W'($past(pos_ff) + ssf_pkg::POS_W'(1)), "digit did not advance")

endmodule

/* hw/rtl/ssf_reading_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_reading_store
// latches readings for the scan path, counts kept as decimal digits and time fields as given
// ----------------------------------------------------------------------------
module ssf_reading_store (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 latch,
   input  ssf_pkg::item_type    item,
   output ssf_pkg::reading_type reading
);

   ssf_pkg::reading_type reading_ff, reading_in;

   always_comb begin
      reading_in.frequency = ssf_pkg::bcd_digits(item.frequency);
      reading_in.distance = ssf_pkg::bcd_digits(16'(item.distance));
      reading_in.temperature = ssf_pkg::bcd_digits(item.temperature);
      reading_in.light = ssf_pkg::bcd_digits(16'(item.light_level));
      reading_in.pot = ssf_pkg::bcd_digits(16'(item.pot_level));
      reading_in.hours = item.time_hours;
      reading_in.minutes = item.time_minutes;
      reading_in.seconds = item.time_seconds;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reading_ff <= '0;
      end else if (latch) begin
         reading_ff <= reading_in;
      end
   end

   assign reading = reading_ff;

endmodule

/* hw/rtl/ssf_formatter.sv */
`timescale 1ns / 1ps
`include "seven_segment_scan_formatter_macros.svh"
// ----------------------------------------------------------------------------
// ssf_formatter
// selects the character for the scanned digit and registers the segment word
// ----------------------------------------------------------------------------
module ssf_formatter (
   input  logic                 clock,
   input  logic                 reset,
   input  ssf_pkg::scan_type    scan,
   input  ssf_pkg::cfg_type     cfg,
   input  ssf_pkg::reading_type reading,
   output logic                 out_free,
   ssf_rsp_if.source            rsp_word
);

   logic       valid_ff, valid_in;
   logic [7:0] strobe_ff, strobe_in;
   logic [7:0] seg_ff, seg_in;
   logic [3:0] code;
   logic [3:0] nib;
   ssf_pkg::bcd5_type three;

   always_comb begin
      three = (cfg.view_mode == ssf_pkg::MODE_DISTANCE) ? reading.distance :
              (cfg.analog_select ? reading.pot : reading.light);
      case (scan.pos)
         3'd0: nib = reading.hours[7:4];
         3'd1: nib = reading.hours[3:0];
         3'd3: nib = reading.minutes[7:4];
         3'd4: nib = reading.minutes[3:0];
         3'd6: nib = reading.seconds[7:4];
         3'd7: nib = reading.seconds[3:0];
         default: nib = '0;
      endcase
      code = ssf_pkg::CHAR_BLANK;
      case (cfg.view_mode)
         ssf_pkg::MODE_FREQ: begin
            case (scan.pos)
               3'd2: code = ssf_pkg::CHAR_DASH;
               3'd3: code = reading.frequency[4];
               3'd4: code = reading.frequency[3];
               3'd5: code = reading.frequency[2];
               3'd6: code = reading.frequency[1];
               3'd7: code = reading.frequency[0];
               default: code = ssf_pkg::CHAR_BLANK;
            endcase
         end
         ssf_pkg::MODE_DISTANCE, ssf_pkg::MODE_ANALOG: begin
            case (scan.pos)
               3'd4: code = ssf_pkg::CHAR_DASH;
               3'd5: code = three[2];
               3'd6: code = three[1];
               3'd7: code = three[0];
               default: code = ssf_pkg::CHAR_BLANK;
            endcase
         end
         ssf_pkg::MODE_TIME: begin
            if (scan.pos inside {3'd2, 3'd5}) begin
               code = ssf_pkg::CHAR_DASH;
            end else if (nib > 4'd9) begin
               code = ssf_pkg::CHAR_BLANK;
            end else begin
               code = nib;
            end
         end
         ssf_pkg::MODE_TEMP: begin
            case (scan.pos)
               3'd4: code = reading.temperature[3];
               3'd5: code = reading.temperature[2];
               3'd6: code = reading.temperature[1];
               3'd7: code = reading.temperature[0];
               default: code = ssf_pkg::CHAR_BLANK;
            endcase
         end
         default: code = ssf_pkg::CHAR_BLANK;
      endcase
   end

   always_comb begin
      seg_in = ssf_pkg::seg_pattern(code);
      if (cfg.view_mode == ssf_pkg::MODE_TIME && (scan.pos inside {3'd2, 3'd5})
          && !scan.blink_on) begin
         seg_in = ssf_pkg::SEG_BLANK;
      end else if (cfg.view_mode == ssf_pkg::MODE_TEMP && scan.pos == 3'd5) begin
         seg_in = seg_in & ssf_pkg::SEG_DP_MASK;
      end
      strobe_in = 8'(1) << scan.pos;
   end

   assign out_free = !valid_ff || rsp_word.ready;
   assign valid_in = scan.fire || (valid_ff && !rsp_word.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (scan.fire) begin
         strobe_ff <= strobe_in;
         seg_ff <= seg_in;
      end
   end

   assign rsp_word.valid = valid_ff;
   assign rsp_word.digit_strobe = strobe_ff;
   assign rsp_word.segments = seg_ff;

   `SSF_ASSERT_IMPLY(a_strobe_onehot, clock, reset, valid_ff, $onehot(strobe_ff),
      "digit strobe not one-hot")
   `SSF_ASSERT_IMPLY(a_no_overwrite, clock, reset, scan.fire, out_free,
      "scan fired into a held word")

endmodule

/* hw/rtl/seven_segment_scan_formatter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_scan_formatter
// eight-digit multiplexed seven-segment driver with apb mode registers
// ----------------------------------------------------------------------------
// Takes one word per clock unless the result side stalls. A word passes an input
// register and then one stage of logic into the result register, and words flow
// back to back at one per cycle while the result side keeps up. An update word
// latches all readings (counts stored as decimal digits, time fields as given)
// and gives no result. Every SCAN_DIVIDER-th tick word drives the next digit,
// 0 through 7, with a one-hot strobe and active-low segments.
// The time-mode dashes blink, BLINK_HALF_SCANS scans on and as many off.
// Mode registers sit at byte addresses 0 (display mode) and 4 (analog select). The
// user must write them only while no word is in flight; the block does not enforce it.
module seven_segment_scan_formatter #(
   parameter int SCAN_DIVIDER = 10,
   parameter int BLINK_HALF_SCANS = 250
) (
   input  logic                               clock,
   input  logic                               reset,
   ssf_req_if.sink                            req_word,
   ssf_rsp_if.source                          rsp_word,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ssf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ssf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ssf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   logic                 in_valid_ff, in_valid_in;
   ssf_pkg::item_type    in_item_ff, in_item_in;
   logic                 advance;
   logic                 out_free;
   logic                 req_take;
   ssf_pkg::cfg_type     cfg;
   ssf_pkg::scan_type    scan;
   ssf_pkg::reading_type reading;

   always_comb begin
      in_item_in.action = req_word.action;
      in_item_in.frequency = req_word.frequency;
      in_item_in.distance = req_word.distance;
      in_item_in.time_hours = req_word.time_hours;
      in_item_in.time_minutes = req_word.time_minutes;
      in_item_in.time_seconds = req_word.time_seconds;
      in_item_in.temperature = req_word.temperature;
      in_item_in.light_level = req_word.light_level;
      in_item_in.pot_level = req_word.pot_level;
   end

   assign advance = in_valid_ff && out_free;
   assign req_word.ready = !in_valid_ff || advance;
   assign req_take = req_word.valid && req_word.ready;
   assign in_valid_in = req_take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= in_item_in;
      end
   end

   ssf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ssf_scan_ctrl #(
      .SCAN_DIVIDER     (SCAN_DIVIDER),
      .BLINK_HALF_SCANS (BLINK_HALF_SCANS)
   ) u_scan_ctrl (
      .clock (clock),
      .reset (reset),
      .tick  (advance && !in_item_ff.action),
      .scan  (scan)
   );

   ssf_reading_store u_reading_store (
      .clock   (clock),
      .reset   (reset),
      .latch   (advance && in_item_ff.action),
      .item    (in_item_ff),
      .reading (reading)
   );

   ssf_formatter u_formatter (
      .clock    (clock),
      .reset    (reset),
      .scan     (scan),
      .cfg      (cfg),
      .reading  (reading),
      .out_free (out_free),
      .rsp_word (rsp_word)
   );

endmodule
